// ===== src/urh_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Shared types and constants for the undo/redo history block.
// Depends on nothing; urh_ifs.sv, undo_redo_history and the bench import it.
package urh_pkg;

    // Fixed field widths of the request, result and configuration channels.
    localparam int REQ_W    = 2;
    localparam int WORD_W   = 32;
    localparam int STATUS_W = 2;
    localparam int CFG_W    = 5;

    // Depth limit after reset, before any clamping to the stack size.
    localparam int LIMIT_RESET = 10;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_PERFORM = 2'd0;
    localparam logic [REQ_W-1:0] REQ_UNDO    = 2'd1;
    localparam logic [REQ_W-1:0] REQ_REDO    = 2'd2;

    // Status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_UNDO   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NO_REDO   = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_UNDO_FULL = 2'd3;

    // One result item as it is held in the output buffer.
    typedef struct packed {
        logic [WORD_W-1:0]   current_state;
        logic                current_valid;
        logic [STATUS_W-1:0] status;
        logic [CFG_W-1:0]    undo_entries;
        logic [CFG_W-1:0]    redo_entries;
    } urh_result_t;

endpackage

`default_nettype wire

// ===== src/urh_ifs.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Valid/ready channel interfaces of the undo/redo history block:
// request input, result output and depth limit write. Uses urh_pkg.

// Request channel: operation code and the word for a perform.
interface urh_req_if import urh_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [REQ_W-1:0]  req_type;
    logic [WORD_W-1:0] new_state;

    modport source (output valid, req_type, new_state, input ready);
    modport sink   (input valid, req_type, new_state, output ready);
endinterface

// Result channel: one result per request.
interface urh_res_if import urh_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [WORD_W-1:0]   current_state;
    logic                current_valid;
    logic [STATUS_W-1:0] status;
    logic [CFG_W-1:0]    undo_entries;
    logic [CFG_W-1:0]    redo_entries;

    modport source (output valid, current_state, current_valid, status,
                    undo_entries, redo_entries, input ready);
    modport sink   (input valid, current_state, current_valid, status,
                    undo_entries, redo_entries, output ready);
endinterface

// Configuration channel: writes the depth limit register.
interface urh_cfg_if import urh_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] depth_limit;

    modport source (output valid, depth_limit, input ready);
    modport sink   (input valid, depth_limit, output ready);
endinterface

`default_nettype wire

// ===== src/undo_redo_history.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Undo/redo history: a current state word and two bounded stacks of earlier words.
// The result of a request is registered in the output buffer when it is accepted.
// Throughput: one request per cycle; ready drops only while both output entries are full.
// Each stack keeps its top word in a register and the rest in a RAM read one entry ahead.
// Reset clears both stack counts, the current word and the output buffer, and sets
// the depth limit to 10 (clamped to the stack size). RAM contents are not cleared.
module undo_redo_history import urh_pkg::*; #(
    parameter int STACK_DEPTH = 16,
    parameter int STATE_WIDTH = 32
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    urh_req_if.sink     req,
    urh_res_if.source   res,
    urh_cfg_if.sink     cfg
);

    localparam int AW  = $clog2(STACK_DEPTH);
    localparam int DW  = $clog2(STACK_DEPTH + 1);
    localparam int LW  = (DW > CFG_W) ? DW : CFG_W;
    localparam int SW  = STATE_WIDTH;
    localparam int XW  = (SW > WORD_W) ? SW : WORD_W;
    localparam int LIM_RST = (STACK_DEPTH < LIMIT_RESET) ? STACK_DEPTH : LIMIT_RESET;

    // Depth limit, held already clamped to the range 1 .. STACK_DEPTH.
    logic [DW-1:0] lim_reg;
    logic [LW-1:0] cfg_ext;
    logic [DW-1:0] lim_next;

    // Current word.
    logic [SW-1:0] cur_reg, cur_next;
    logic          present_reg, present_next;

    // Undo stack: count, cached top word, RAM for the words below it.
    logic [DW-1:0] u_depth_reg, u_depth_next;
    logic [SW-1:0] u_top_reg, u_top_next;
    logic [SW-1:0] u_rdata, u_second;
    logic          u_byp_reg;
    logic [SW-1:0] u_byp_data_reg;
    logic          u_push, u_pop, u_full, u_we;
    logic [AW-1:0] u_waddr, u_raddr;

    // Redo stack, same organization.
    logic [DW-1:0] r_depth_reg, r_depth_next;
    logic [SW-1:0] r_top_reg, r_top_next;
    logic [SW-1:0] r_rdata, r_second;
    logic          r_byp_reg;
    logic [SW-1:0] r_byp_data_reg;
    logic          r_push, r_pop, r_full, r_clear, r_we;
    logic [AW-1:0] r_waddr, r_raddr;

    // Request decode and result.
    logic                in_fire;
    logic [SW-1:0]       word_in;
    logic [STATUS_W-1:0] status;
    urh_result_t         result;

    // Output buffer: result register plus one skid entry.
    urh_result_t out_reg, skid_reg;
    logic        out_valid_reg, skid_valid_reg;
    logic        out_fire;

    assign in_fire   = req.valid && req.ready;
    assign out_fire  = out_valid_reg && res.ready;
    assign req.ready = !skid_valid_reg;
    assign cfg.ready = 1'b1;
    assign word_in   = SW'(XW'(req.new_state));

    // Clamp a written limit: zero acts as one, large values as the stack size.
    always_comb
    begin
        cfg_ext = LW'(cfg.depth_limit);
        if (cfg_ext == '0)
        begin
            lim_next = DW'(1);
        end
        else if (cfg_ext > LW'(STACK_DEPTH))
        begin
            lim_next = DW'(STACK_DEPTH);
        end
        else
        begin
            lim_next = DW'(cfg_ext);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lim_reg <= DW'(LIM_RST);
        end
        else if (cfg.valid)
        begin
            lim_reg <= lim_next;
        end
    end

    // Second-from-top words, taking a word written in the previous cycle from the bypass.
    assign u_second = u_byp_reg ? u_byp_data_reg : u_rdata;
    assign r_second = r_byp_reg ? r_byp_data_reg : r_rdata;
    assign u_full   = (u_depth_reg >= lim_reg);
    assign r_full   = (r_depth_reg >= lim_reg);

    // Decide the pushes and pops that the request causes, and its status.
    always_comb
    begin
        u_push       = 1'b0;
        u_pop        = 1'b0;
        r_push       = 1'b0;
        r_pop        = 1'b0;
        r_clear      = 1'b0;
        status       = STATUS_OK;
        cur_next     = cur_reg;
        present_next = present_reg;
        if (in_fire)
        begin
            case (req.req_type)
                REQ_PERFORM:
                begin
                    if (present_reg)
                    begin
                        if (u_full)
                        begin
                            status = STATUS_UNDO_FULL;
                        end
                        else
                        begin
                            u_push = 1'b1;
                        end
                    end
                    cur_next     = word_in;
                    present_next = 1'b1;
                    r_clear      = 1'b1;
                end
                REQ_UNDO:
                begin
                    if (u_depth_reg == '0)
                    begin
                        status = STATUS_NO_UNDO;
                    end
                    else
                    begin
                        r_push   = !r_full;
                        u_pop    = 1'b1;
                        cur_next = u_top_reg;
                    end
                end
                REQ_REDO:
                begin
                    if (r_depth_reg == '0)
                    begin
                        status = STATUS_NO_REDO;
                    end
                    else
                    begin
                        if (u_full)
                        begin
                            status = STATUS_UNDO_FULL;
                        end
                        else
                        begin
                            u_push = 1'b1;
                        end
                        r_pop    = 1'b1;
                        cur_next = r_top_reg;
                    end
                end
                default:
                begin
                    status = STATUS_OK;
                end
            endcase
        end
    end

    // Undo stack next state and RAM access.
    always_comb
    begin
        u_depth_next = u_depth_reg;
        u_top_next   = u_top_reg;
        if (u_push)
        begin
            u_depth_next = u_depth_reg + DW'(1);
            u_top_next   = cur_reg;
        end
        else if (u_pop)
        begin
            u_depth_next = u_depth_reg - DW'(1);
            u_top_next   = u_second;
        end
    end

    assign u_we    = u_push && (u_depth_reg != '0);
    assign u_waddr = AW'(u_depth_reg - DW'(1));
    assign u_raddr = AW'(u_depth_next - DW'(2));

    // Redo stack next state and RAM access.
    always_comb
    begin
        r_depth_next = r_depth_reg;
        r_top_next   = r_top_reg;
        if (r_clear)
        begin
            r_depth_next = '0;
        end
        else if (r_push)
        begin
            r_depth_next = r_depth_reg + DW'(1);
            r_top_next   = cur_reg;
        end
        else if (r_pop)
        begin
            r_depth_next = r_depth_reg - DW'(1);
            r_top_next   = r_second;
        end
    end

    assign r_we    = r_push && (r_depth_reg != '0);
    assign r_waddr = AW'(r_depth_reg - DW'(1));
    assign r_raddr = AW'(r_depth_next - DW'(2));

    urh_ram #(
        .WIDTH (SW),
        .DEPTH (STACK_DEPTH)
    ) u_undo_ram (
        .clk   (clk),
        .we    (u_we),
        .waddr (u_waddr),
        .wdata (u_top_reg),
        .raddr (u_raddr),
        .rdata (u_rdata)
    );

    urh_ram #(
        .WIDTH (SW),
        .DEPTH (STACK_DEPTH)
    ) u_redo_ram (
        .clk   (clk),
        .we    (r_we),
        .waddr (r_waddr),
        .wdata (r_top_reg),
        .raddr (r_raddr),
        .rdata (r_rdata)
    );

    // Stack counts, current word and bypass flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            u_depth_reg <= '0;
            r_depth_reg <= '0;
            cur_reg     <= '0;
            present_reg <= 1'b0;
            u_byp_reg   <= 1'b0;
            r_byp_reg   <= 1'b0;
        end
        else
        begin
            u_depth_reg <= u_depth_next;
            r_depth_reg <= r_depth_next;
            cur_reg     <= cur_next;
            present_reg <= present_next;
            u_byp_reg   <= u_we && (u_waddr == u_raddr);
            r_byp_reg   <= r_we && (r_waddr == r_raddr);
        end
    end

    // Top words and bypass data need no reset.
    always_ff @(posedge clk)
    begin
        u_top_reg      <= u_top_next;
        r_top_reg      <= r_top_next;
        u_byp_data_reg <= u_top_reg;
        r_byp_data_reg <= r_top_reg;
    end

    // Result of the request being accepted.
    always_comb
    begin
        result.current_state = WORD_W'(XW'(cur_next));
        result.current_valid = present_next;
        result.status        = status;
        result.undo_entries  = CFG_W'(LW'(u_depth_next));
        result.redo_entries  = CFG_W'(LW'(r_depth_next));
    end

    // Output buffer control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (in_fire)
        begin
            if (out_valid_reg && !out_fire)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (out_fire)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output buffer data.
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (in_fire)
        begin
            if (out_valid_reg && !out_fire)
            begin
                skid_reg <= result;
            end
            else
            begin
                out_reg <= result;
            end
        end
    end

    assign res.valid         = out_valid_reg;
    assign res.current_state = out_reg.current_state;
    assign res.current_valid = out_reg.current_valid;
    assign res.status        = out_reg.status;
    assign res.undo_entries  = out_reg.undo_entries;
    assign res.redo_entries  = out_reg.redo_entries;

    // Neither stack ever holds more words than the stack size.
    assert property (@(posedge clk) disable iff (!rst_n)
        (u_depth_reg <= DW'(STACK_DEPTH)) && (r_depth_reg <= DW'(STACK_DEPTH)))
    else $error("stack count above stack size");

    // The skid entry is only occupied behind a waiting result.
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
    else $error("skid entry holds a result while the output register is empty");

    // A perform always leaves the redo stack empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && (req.req_type == REQ_PERFORM) |=> (r_depth_reg == '0))
    else $error("redo stack not emptied by a perform");

    // The undo count and the current word only move when a request is accepted.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_fire |=> $stable(u_depth_reg) && $stable(cur_reg))
    else $error("history state changed without a request");

    // A nonempty undo stack implies a current word exists.
    assert property (@(posedge clk) disable iff (!rst_n)
        (u_depth_reg != '0) |-> present_reg)
    else $error("undo entries without a current word");

endmodule

`default_nettype wire

// ===== src/urh_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Generic single-write, single-read RAM with a registered read port.
// A read of the address being written returns the old contents. No dependencies.
module urh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the undo/redo history block: drives requests and depth limit
// writes, and checks every result against a built-in model of the two history stacks.
// Depends on urh_pkg, the channel interfaces of urh_ifs.sv and undo_redo_history.

module tb;
    import urh_pkg::*;

    localparam int HIST_DEPTH     = 16;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int REPORT_LIMIT   = 10;

    // Stack selectors for the model.
    localparam int UNDO_SIDE = 0;
    localparam int REDO_SIDE = 1;

    // The request code that the block leaves undefined.
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    // Kinds of request runs in the random part.
    localparam int RUN_PERFORM = 0;
    localparam int RUN_UNDO    = 1;
    localparam int RUN_REDO    = 2;
    localparam int RUN_MIXED   = 3;

    // Model of the history: current word, both stacks and the depth limit.
    // Each accepted request leaves one expected snapshot of the result.
    class history_tracker;
        logic [WORD_W-1:0] stack_words[2][HIST_DEPTH];
        int unsigned       stack_fill[2];
        logic [WORD_W-1:0] cur_word;
        bit                cur_present;
        logic [CFG_W-1:0]  limit_reg;
        urh_result_t       pending_snapshots[$];
        int                fault_count;
        int                request_count;
        int                op_count[4];
        int                status_count[4];

        function new();
            cur_word    = '0;
            cur_present = 1'b0;
            limit_reg   = CFG_W'(LIMIT_RESET);
        endfunction

        function void write_limit(logic [CFG_W-1:0] value);
            limit_reg = value;
        endfunction

        // A limit of zero acts as one; anything above the stack size acts as the size.
        function int unsigned active_limit();
            if (limit_reg == 0)
                return 1;
            if (limit_reg > HIST_DEPTH)
                return HIST_DEPTH;
            return limit_reg;
        endfunction

        // Returns 0 when the stack is at its limit, so the word is dropped.
        function bit push_word(int side, logic [WORD_W-1:0] word);
            if (stack_fill[side] >= active_limit())
                return 1'b0;
            stack_words[side][stack_fill[side]] = word;
            stack_fill[side]++;
            return 1'b1;
        endfunction

        function logic [WORD_W-1:0] pop_word(int side);
            stack_fill[side]--;
            return stack_words[side][stack_fill[side]];
        endfunction

        // Applies one accepted request and queues the result it must produce.
        function void apply_request(logic [REQ_W-1:0] op, logic [WORD_W-1:0] word);
            logic [STATUS_W-1:0] st;
            urh_result_t         snap;
            st = STATUS_OK;
            case (op)
                REQ_PERFORM:
                begin
                    if (cur_present && !push_word(UNDO_SIDE, cur_word))
                        st = STATUS_UNDO_FULL;
                    cur_word    = word;
                    cur_present = 1'b1;
                    stack_fill[REDO_SIDE] = 0;
                end
                REQ_UNDO:
                begin
                    if (stack_fill[UNDO_SIDE] == 0)
                        st = STATUS_NO_UNDO;
                    else
                    begin
                        // A full redo stack silently drops the word.
                        void'(push_word(REDO_SIDE, cur_word));
                        cur_word = pop_word(UNDO_SIDE);
                    end
                end
                REQ_REDO:
                begin
                    if (stack_fill[REDO_SIDE] == 0)
                        st = STATUS_NO_REDO;
                    else
                    begin
                        if (!push_word(UNDO_SIDE, cur_word))
                            st = STATUS_UNDO_FULL;
                        cur_word = pop_word(REDO_SIDE);
                    end
                end
                default: ;
            endcase
            snap.current_state = cur_word;
            snap.current_valid = cur_present;
            snap.status        = st;
            snap.undo_entries  = CFG_W'(stack_fill[UNDO_SIDE]);
            snap.redo_entries  = CFG_W'(stack_fill[REDO_SIDE]);
            pending_snapshots.push_back(snap);
            request_count++;
            op_count[op]++;
            status_count[st]++;
        endfunction

        function string describe(urh_result_t r);
            return $sformatf("state %h valid %0d status %0d undo %0d redo %0d",
                             r.current_state, r.current_valid, r.status,
                             r.undo_entries, r.redo_entries);
        endfunction

        function void note_fault(string msg);
            fault_count++;
            if (fault_count <= REPORT_LIMIT)
                $display("[%0t] check failed: %s", $time, msg);
        endfunction

        // Compares one accepted result with the oldest expected snapshot.
        function void check_snapshot(urh_result_t got);
            urh_result_t exp;
            string       bad;
            if (pending_snapshots.size() == 0)
            begin
                note_fault({"result with no request pending: ", describe(got)});
                return;
            end
            exp = pending_snapshots.pop_front();
            bad = "";
            if (got.current_state !== exp.current_state)
                bad = {bad, " current_state"};
            if (got.current_valid !== exp.current_valid)
                bad = {bad, " current_valid"};
            if (got.status !== exp.status)
                bad = {bad, " status"};
            if (got.undo_entries !== exp.undo_entries)
                bad = {bad, " undo_entries"};
            if (got.redo_entries !== exp.redo_entries)
                bad = {bad, " redo_entries"};
            if (bad != "")
                note_fault({"mismatch in", bad, ": expected ", describe(exp),
                            "; got ", describe(got)});
        endfunction

        function void finish_check();
            if (pending_snapshots.size() != 0)
                note_fault($sformatf("%0d results never came, oldest: %s",
                                     pending_snapshots.size(),
                                     describe(pending_snapshots[0])));
        endfunction
    endclass

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    bit   no_idle;
    int   limit_writes;

    urh_req_if req_ch ();
    urh_res_if res_ch ();
    urh_cfg_if cfg_ch ();

    history_tracker history = new();

    undo_redo_history #(
        .STACK_DEPTH (HIST_DEPTH),
        .STATE_WIDTH (WORD_W)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .res   (res_ch),
        .cfg   (cfg_ch)
    );

    always #1 clk = ~clk;

    // Idle gap length: mostly none, some short, a few long.
    function automatic int pick_gap();
        int roll;
        if (no_idle)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 65)
            return 0;
        if (roll < 93)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    // State words favor the all-zero and all-one extremes now and then.
    function automatic logic [WORD_W-1:0] random_word();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    // Result side: ready drops for random stretches.
    initial
    begin : result_sink
        int stall;
        res_ch.ready = 1'b0;
        stall = 0;
        forever
        begin
            @(negedge clk);
            if (stall > 0)
            begin
                stall--;
                res_ch.ready <= 1'b0;
            end
            else
            begin
                res_ch.ready <= 1'b1;
                stall = pick_gap();
            end
        end
    end

    // Handshakes are sampled at the rising edge and fed to the model.
    always @(posedge clk)
    begin : monitor
        urh_result_t got;
        if (req_ch.valid && req_ch.ready)
            history.apply_request(req_ch.req_type, req_ch.new_state);
        if (res_ch.valid && res_ch.ready)
        begin
            got.current_state = res_ch.current_state;
            got.current_valid = res_ch.current_valid;
            got.status        = res_ch.status;
            got.undo_entries  = res_ch.undo_entries;
            got.redo_entries  = res_ch.redo_entries;
            history.check_snapshot(got);
        end
        if (cfg_ch.valid && cfg_ch.ready)
            history.write_limit(cfg_ch.depth_limit);
    end

    // Ends the run when no channel has moved anything for too long.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    // Sends one request after a random gap; valid stays high when no gap follows.
    task automatic send_request(logic [REQ_W-1:0] op, logic [WORD_W-1:0] word);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            req_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        req_ch.valid     <= 1'b1;
        req_ch.req_type  <= op;
        req_ch.new_state <= word;
        do @(posedge clk); while (!req_ch.ready);
    endtask

    // Stops sending and waits until every expected result has arrived.
    task automatic hold_requests();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (history.pending_snapshots.size() != 0)
            @(posedge clk);
    endtask

    // Writes the depth limit once the block is idle.
    task automatic program_limit(logic [CFG_W-1:0] value);
        hold_requests();
        @(negedge clk);
        cfg_ch.valid       <= 1'b1;
        cfg_ch.depth_limit <= value;
        do @(posedge clk); while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
        limit_writes++;
    endtask

    // Random runs of one request kind, or of mixed kinds, drive the stacks to full and to empty.
    task automatic run_phase(int count);
        int               sent;
        int               kind;
        int               run_len;
        int               i;
        logic [REQ_W-1:0] op;
        sent = 0;
        while (sent < count)
        begin
            kind    = $urandom_range(RUN_PERFORM, RUN_MIXED);
            run_len = $urandom_range(1, 20);
            for (i = 0; i < run_len && sent < count; i++)
            begin
                case (kind)
                    RUN_PERFORM: op = REQ_PERFORM;
                    RUN_UNDO:    op = REQ_UNDO;
                    RUN_REDO:    op = REQ_REDO;
                    default:     op = REQ_W'($urandom_range(0, 3));
                endcase
                send_request(op, random_word());
                sent++;
                if ($urandom_range(0, 59) == 0)
                    hold_requests();
            end
        end
    endtask

    initial
    begin : stimulus
        logic [CFG_W-1:0] phase_limits[8];
        int               p;
        req_ch.valid       = 1'b0;
        req_ch.req_type    = REQ_PERFORM;
        req_ch.new_state   = '0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.depth_limit = '0;
        no_idle            = 1'b0;
        limit_writes       = 0;
        phase_limits = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd7, 5'd23, 5'd2, 5'd12};
        phase_limits[7] = CFG_W'($urandom_range(2, 15));

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Empty history: both pops refuse, the unused code does nothing.
        send_request(REQ_UNDO, '1);
        send_request(REQ_REDO, 32'h1234_5678);
        send_request(REQ_UNUSED, '1);
        // Extreme words, then a few more to fill undo past one entry.
        send_request(REQ_PERFORM, '0);
        send_request(REQ_PERFORM, '1);
        send_request(REQ_UNUSED, '0);
        send_request(REQ_PERFORM, 32'h1234_5678);
        send_request(REQ_PERFORM, 32'h8765_4321);
        send_request(REQ_UNDO, '0);

        // Zero limit acts as one and sits below the undo fill: pushes fail, pops work.
        program_limit('0);
        send_request(REQ_REDO, '0);
        send_request(REQ_PERFORM, 32'hDEAD_BEEF);
        send_request(REQ_UNDO, '0);
        send_request(REQ_UNDO, '0);
        send_request(REQ_UNDO, '0);
        send_request(REQ_UNDO, '0);
        send_request(REQ_REDO, '0);
        send_request(REQ_REDO, '0);
        send_request(REQ_UNDO, '0);
        send_request(REQ_REDO, '0);
        send_request(REQ_PERFORM, 32'h5A5A_A5A5);

        // Random phases under a range of limits, some with no idling at all.
        for (p = 0; p < 8; p++)
        begin
            program_limit(phase_limits[p]);
            no_idle = (p % 3 == 2);
            run_phase(85);
        end
        no_idle = 1'b0;

        hold_requests();
        repeat (8) @(posedge clk);
        history.finish_check();

        $display("Ran %0d requests (perform %0d, undo %0d, redo %0d, unused %0d), %0d limit writes.",
                 history.request_count, history.op_count[REQ_PERFORM],
                 history.op_count[REQ_UNDO], history.op_count[REQ_REDO],
                 history.op_count[REQ_UNUSED], limit_writes);
        $display("Statuses: ok %0d, nothing to undo %0d, nothing to redo %0d, undo full %0d; faults %0d.",
                 history.status_count[STATUS_OK], history.status_count[STATUS_NO_UNDO],
                 history.status_count[STATUS_NO_REDO], history.status_count[STATUS_UNDO_FULL],
                 history.fault_count);
        if (history.fault_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
